/* rtl/fba_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fba_pkg: shared types and constants
// Payload structs, command and status bundles, codes and the controller state
// type of the first-fit frame bitmap allocator.
// ----------------------------------------------------------------------------
package fba_pkg;

  localparam int DEF_NUM_FRAMES = 4096;
  localparam int WORD_BITS      = 32;
  localparam int FIELD_FRAMES   = 4096;
  localparam int FIELD_WORDS    = FIELD_FRAMES / WORD_BITS;
  localparam int GROUP_SIZE     = 16;
  localparam int FRAME_W        = 12;
  localparam int COUNT_W        = 13;

  localparam logic [COUNT_W-1:0] FRAME_COUNT_RESET = 13'h1000;

  localparam logic [1:0] KIND_ALLOC = 2'd0;
  localparam logic [1:0] KIND_FREE  = 2'd1;
  localparam logic [1:0] KIND_TEST  = 2'd2;

  localparam logic [2:0] STATUS_ALLOCATED = 3'd0;
  localparam logic [2:0] STATUS_MAPPED    = 3'd1;
  localparam logic [2:0] STATUS_NO_FRAME  = 3'd2;
  localparam logic [2:0] STATUS_FREED     = 3'd3;
  localparam logic [2:0] STATUS_NONE      = 3'd4;

  typedef struct packed {
    logic [1:0]         kind;
    logic [FRAME_W-1:0] frame_number;
    logic               kernel_page;
    logic               write_access;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [FRAME_W-1:0] new_frame;
    logic               present_bit;
    logic               writable_bit;
    logic               user_bit;
    logic               frame_in_use;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic rd_search;
    logic scan;
    logic pick;
    logic res_ld;
    logic commit;
    logic out_ld;
  } cmd_t;

  typedef struct packed {
    logic direct;
    logic need_read;
    logic need_search;
    logic found;
  } stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_PICK,
    S_CHECK,
    S_READ,
    S_DONE
  } fsm_state_t;

endpackage
`default_nettype wire

/* rtl/fba_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fba_datapath: bitmap store, free-word search and result registers
// Holds the frame bitmap in a word memory with per-row valid and full flags,
// finds the first non-full word through a two-level registered encoder, and
// forms the result transaction.
// ----------------------------------------------------------------------------
module fba_datapath #(
  parameter int NUM_FRAMES = fba_pkg::DEF_NUM_FRAMES
) (
  input  wire                        clk,
  input  wire                        rst,
  input  fba_pkg::in_item_t          in_data,
  input  wire                        cfg_wr_en,
  input  wire [fba_pkg::COUNT_W-1:0] cfg_wr_data,
  input  fba_pkg::cmd_t              cmd,
  output fba_pkg::stat_t             stat,
  output fba_pkg::out_item_t         out_data
);
  import fba_pkg::*;

  localparam int RAW_WORDS = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int DEPTH     = (RAW_WORDS > FIELD_WORDS) ? FIELD_WORDS : RAW_WORDS;
  localparam int MAXW      = (NUM_FRAMES / WORD_BITS > FIELD_WORDS) ? FIELD_WORDS
                                                                   : NUM_FRAMES / WORD_BITS;
  localparam int WIDX      = $clog2(DEPTH);
  localparam int NGROUPS   = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int GIDXW     = (NGROUPS > 1) ? $clog2(NGROUPS) : 1;
  localparam int SUBW      = $clog2(GROUP_SIZE);
  localparam int PADN      = NGROUPS * GROUP_SIZE;

  logic [COUNT_W-1:0]   frame_count;
  in_item_t             item;
  logic [31:0]          mem [DEPTH];
  logic [DEPTH-1:0]     row_valid;
  logic [DEPTH-1:0]     full;
  logic [31:0]          rdata;
  logic                 rdata_valid;
  logic [NGROUPS-1:0]   grp_any;
  logic [SUBW-1:0]      grp_idx [NGROUPS];
  logic [WIDX-1:0]      word_q;
  logic                 found_q;
  out_item_t            res;

  logic [7:0]           fc_words;
  logic [7:0]           limit;
  logic [DEPTH-1:0]     elig;
  logic [PADN-1:0]      elig_pad;
  logic [NGROUPS-1:0]   grp_any_next;
  logic [SUBW-1:0]      grp_idx_next [NGROUPS];
  logic [GIDXW+SUBW-1:0] word_pad;
  logic                 managed;
  logic                 is_alloc;
  logic                 is_free;
  logic                 is_test;
  logic                 free_ok;
  logic                 test_ok;
  logic [WIDX-1:0]      item_word;
  logic [WIDX-1:0]      addr;
  logic [31:0]          rdata_eff;
  logic [4:0]           free_bit;
  logic [31:0]          alloc_mask;
  logic [31:0]          free_mask;
  logic                 mem_we;
  logic [31:0]          wdata;
  out_item_t            res_next;

  assign managed   = 32'(item.frame_number) < NUM_FRAMES;
  assign is_alloc  = item.kind == KIND_ALLOC;
  assign is_free   = item.kind == KIND_FREE;
  assign is_test   = item.kind == KIND_TEST;
  assign free_ok   = is_free && (item.frame_number != '0) && managed;
  assign test_ok   = is_test && managed;
  assign item_word = item.frame_number[5 +: WIDX];

  assign stat.need_search = is_alloc && (item.frame_number == '0);
  assign stat.need_read   = free_ok || test_ok;
  assign stat.direct      = !stat.need_search && !stat.need_read;
  assign stat.found       = found_q;

  assign fc_words = frame_count[COUNT_W-1:5];
  assign limit    = (fc_words > 8'(MAXW)) ? 8'(MAXW) : fc_words;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      elig[i] = !full[i] && (8'(i) < limit);
    end
    elig_pad = PADN'(elig);
    for (int g = 0; g < NGROUPS; g++) begin
      grp_any_next[g] = |elig_pad[g*GROUP_SIZE +: GROUP_SIZE];
      grp_idx_next[g] = '0;
      for (int j = GROUP_SIZE - 1; j >= 0; j--) begin
        if (elig_pad[g*GROUP_SIZE + j]) begin
          grp_idx_next[g] = SUBW'(j);
        end
      end
    end
    word_pad = '0;
    for (int g = NGROUPS - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        word_pad = {GIDXW'(g), grp_idx[g]};
      end
    end
  end

  assign addr      = (cmd.rd_search || is_alloc) ? word_q : item_word;
  assign rdata_eff = rdata_valid ? rdata : '0;

  always_comb begin
    free_bit = '0;
    for (int j = 31; j >= 0; j--) begin
      if (!rdata_eff[j]) begin
        free_bit = 5'(j);
      end
    end
  end

  assign alloc_mask = 32'(1) << free_bit;
  assign free_mask  = 32'(1) << item.frame_number[4:0];
  assign mem_we     = cmd.commit && (is_alloc || is_free);
  assign wdata      = is_alloc ? (rdata_eff | alloc_mask) : (rdata_eff & ~free_mask);

  always_comb begin
    res_next        = '0;
    res_next.status = STATUS_NONE;
    if (is_alloc) begin
      if (item.frame_number != '0) begin
        res_next.status    = STATUS_MAPPED;
        res_next.new_frame = item.frame_number;
      end else if (!found_q) begin
        res_next.status = STATUS_NO_FRAME;
      end else begin
        res_next.status       = STATUS_ALLOCATED;
        res_next.new_frame    = FRAME_W'({word_q, free_bit});
        res_next.present_bit  = 1'b1;
        res_next.writable_bit = item.write_access;
        res_next.user_bit     = !item.kernel_page;
      end
    end else if (free_ok) begin
      res_next.status = STATUS_FREED;
    end else if (test_ok) begin
      res_next.frame_in_use = rdata_eff[item.frame_number[4:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= FRAME_COUNT_RESET;
      row_valid   <= '0;
      full        <= '0;
      found_q     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        frame_count <= cfg_wr_data;
      end
      if (mem_we) begin
        row_valid[addr] <= 1'b1;
        full[addr]      <= &wdata;
      end
      if (cmd.pick) begin
        found_q <= |grp_any;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= wdata;
    end
    if (cmd.rd) begin
      rdata       <= mem[addr];
      rdata_valid <= row_valid[addr];
    end
    if (cmd.load) begin
      item <= in_data;
    end
    if (cmd.scan) begin
      grp_any <= grp_any_next;
      for (int g = 0; g < NGROUPS; g++) begin
        grp_idx[g] <= grp_idx_next[g];
      end
    end
    if (cmd.pick) begin
      word_q <= word_pad[WIDX-1:0];
    end
    if (cmd.res_ld) begin
      res <= res_next;
    end
    if (cmd.out_ld) begin
      out_data <= res;
    end
  end

  a_alloc_sets_clear_bit: assert property (@(posedge clk) disable iff (rst)
    (mem_we && is_alloc) |-> ($countones(wdata) == $countones(rdata_eff) + 1))
    else $error("allocation did not set exactly one clear bit");

  a_free_sets_nothing: assert property (@(posedge clk) disable iff (rst)
    (mem_we && is_free) |-> ((wdata & ~rdata_eff) == '0))
    else $error("free set a bitmap bit");

  a_pick_eligible: assert property (@(posedge clk) disable iff (rst)
    cmd.pick |=> (!found_q || (!full[word_q] && (8'(word_q) < limit))))
    else $error("search picked a full or out-of-range word");

endmodule
`default_nettype wire

/* rtl/fba_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// fba_ctrl: allocator controller
// Sequences decode, search, memory read, update and result hand-off for one
// transaction at a time and owns the output valid flag.
// ----------------------------------------------------------------------------
module fba_ctrl (
  input  wire             clk,
  input  wire             rst,
  input  wire             in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  wire             out_stall,
  input  fba_pkg::stat_t  stat,
  output fba_pkg::cmd_t   cmd
);
  import fba_pkg::*;

  fsm_state_t state;
  fsm_state_t state_next;
  logic       out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= cmd.out_ld || (out_valid && out_stall);
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        priority if (stat.need_search) state_next = S_SCAN;
        else if (stat.need_read)       state_next = S_READ;
        else                           state_next = S_DONE;
      end
      S_SCAN:  state_next = S_PICK;
      S_PICK:  state_next = S_CHECK;
      S_CHECK: state_next = stat.found ? S_READ : S_DONE;
      S_READ:  state_next = S_DONE;
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_DECODE: begin
        cmd.rd     = !stat.need_search && stat.need_read;
        cmd.res_ld = stat.direct;
      end
      S_SCAN: cmd.scan = 1'b1;
      S_PICK: cmd.pick = 1'b1;
      S_CHECK: begin
        cmd.rd        = stat.found;
        cmd.rd_search = stat.found;
        cmd.res_ld    = !stat.found;
      end
      S_READ: begin
        cmd.res_ld = 1'b1;
        cmd.commit = 1'b1;
      end
      S_DONE: cmd.out_ld = out_free;
      default: cmd = '0;
    endcase
  end

  a_read_follows_issue: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ) |-> ($past(state) == S_DECODE || $past(state) == S_CHECK))
    else $error("read state entered without a memory read");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_ld |-> (!out_valid || !out_stall))
    else $error("pending result overwritten");

endmodule
`default_nettype wire

/* rtl/frame_bitmap_allocator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// frame_bitmap_allocator: first-fit physical frame bitmap allocator
// Allocates, frees and tests 4 KiB frames held in a one-bit-per-frame map.
// ----------------------------------------------------------------------------
// An allocate that searches passes through scan, pick and check, then a
// registered read of the bitmap memory if it finds a frame; a free or test
// that reads the map passes through that read; all else goes straight to the
// result. A new transaction is taken only after the last result has been
// loaded into the output register. Reset clears every frame at once through
// per-word valid flags, sets frame_count to 4096 and leaves the block idle.
module frame_bitmap_allocator #(
  parameter int NUM_FRAMES = fba_pkg::DEF_NUM_FRAMES
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        in_valid,
  output logic                       in_stall,
  input  fba_pkg::in_item_t          in_data,
  output logic                       out_valid,
  input  wire                        out_stall,
  output fba_pkg::out_item_t         out_data,
  input  wire                        cfg_wr_en,
  input  wire [fba_pkg::COUNT_W-1:0] cfg_wr_data
);
  import fba_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  fba_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  fba_datapath #(
    .NUM_FRAMES (NUM_FRAMES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .in_data     (in_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .stat        (stat),
    .out_data    (out_data)
  );

endmodule
`default_nettype wire
